// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Both macros sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked only outside of reset.
`define SMMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A property that is checked at every edge, reset included.
`define SMMA_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/smma_pkg.sv -----
`timescale 1ns / 1ps

package smma_pkg;

	// Width of the window length register.
	localparam int CFG_WIDTH = 9;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	// Status that the divider reports to the sequencer.
	typedef struct packed {
		logic done;
		logic sat;
	} div_status_t;

endpackage

// ----- rtl/smma_ring.sv -----
`timescale 1ns / 1ps

module smma_ring #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read-first: a read of the entry being written returns the old content.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/smma_div.sv -----
`timescale 1ns / 1ps

module smma_div
	import smma_pkg::*;
#(
	parameter int NW = 54,
	parameter int QW = 18,
	parameter int SW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic        [QW-1:0] den,
	output logic signed [SW-1:0] avg,
	output div_status_t          status
);

	localparam int CNTW = $clog2(NW + 1);
	localparam logic [NW-1:0] NEG_LIM = NW'(1) << (SW - 1);
	localparam logic [NW-1:0] POS_LIM = NEG_LIM - NW'(1);
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW - 1){1'b0}}};

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic [QW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;

	logic [QW:0]   shifted;
	logic          fits;
	logic          over;
	logic [NW-1:0] signed_res;

	// One quotient bit per cycle, restoring, on the magnitude of the numerator.
	assign shifted = {rem_q, quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNTW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			rem_q <= '0;
			quo_q <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
		end else if (busy_q) begin
			rem_q <= fits ? QW'(shifted - {1'b0, den}) : QW'(shifted);
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	// Truncation toward zero falls out of dividing the magnitude.
	always_comb begin
		over       = neg_q ? (quo_q > NEG_LIM) : (quo_q > POS_LIM);
		signed_res = neg_q ? (~quo_q + NW'(1)) : quo_q;
		if (over) begin
			avg = neg_q ? SMIN : SMAX;
		end else begin
			avg = $signed(signed_res[SW-1:0]);
		end
		status.done = done_q;
		status.sat  = over;
	end

endmodule

// ----- rtl/sharp_modified_moving_average_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// config    in         cfg_we               window_length[8:0]
// input     in         in_valid/in_ready    sample
// output    out        out_valid/out_ready  average, saturated
//
// A warm-up sample passes only through the accumulate state; a later one also
// through the multiply, divide and output states. No new sample is taken until
// it is done. Bit-serial divider width NW = SAMPLE_WIDTH + 2*clog2(MAX_WINDOW+1) + 4.
// Reset clears the sums, the ring position and the warm-up count at once; the
// ring memory needs no clearing pass, since only written entries are read.
// A stalled output beat is held in an output register while a new beat is taken.

module sharp_modified_moving_average_top
	import smma_pkg::*;
#(
	parameter int MAX_WINDOW   = 256,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [CFG_WIDTH-1:0]           window_length,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic                           saturated
);

	// Widths of the exact integer sums. PW holds the effective window length,
	// the sums get enough headroom for a window plus the sample that is
	// about to leave it.
	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = $clog2(MAX_WINDOW);
	localparam int PW = $clog2(MAX_WINDOW + 1);
	localparam int CW = PW + 2;
	localparam int TW = SW + PW + 1;
	localparam int DW = SW + 2 * PW + 1;
	localparam int NW = DW + 3;
	localparam int QW = 2 * PW;
	localparam int MW = TW + PW + 2;
	localparam int OW = SW + PW + 2;

	// Configuration: the effective window p and the divisor p*(p+1), both
	// computed once when the register is written.
	logic [PW-1:0] p_q;
	logic [QW-1:0] den_q;
	logic [PW-1:0] p_new;
	logic [QW-1:0] den_new;

	// Running state.
	logic [AW-1:0]          pos_q;
	logic [PW-1:0]          w_q;
	logic signed [TW-1:0]   t_q;
	logic signed [DW-1:0]   d_q;

	// Pipeline registers of one sample's update.
	logic signed [SW-1:0]   x_s1;
	logic signed [SW+CW-1:0] prod_s1;
	logic                   warm_s1;
	logic signed [MW-1:0]   tp_s2;
	logic signed [OW-1:0]   oldp_s2;
	logic signed [SW-1:0]   old_s2;

	// Output register.
	logic                   out_valid_q;
	logic signed [SW-1:0]   avg_q;
	logic                   sat_q;

	// Sequencer.
	state_t state_q;
	state_t state_d;
	logic   div_start;
	logic   out_load;
	logic   accept;

	logic                   warm_c;
	logic signed [CW-1:0]   coef;
	logic [PW+1:0]          p_plus1;
	logic [AW:0]            old_sum;
	logic [AW-1:0]          oldest_addr;
	logic [AW-1:0]          pos_next;
	logic [SW-1:0]          ring_rdata;
	logic signed [SW-1:0]   old_sel;
	logic signed [NW-1:0]   num_c;
	logic signed [SW-1:0]   div_avg;
	div_status_t            div_stat;

	// A window length of zero acts as one; any length above the ring depth acts
	// as the ring depth.
	always_comb begin
		priority if (window_length == '0) begin
			p_new = PW'(1);
		end else if (int'(window_length) > MAX_WINDOW) begin
			p_new = PW'(MAX_WINDOW);
		end else begin
			p_new = PW'(window_length);
		end
		den_new = QW'(p_new) * (QW'(p_new) + QW'(1));
	end

	assign accept  = in_valid && in_ready;
	assign p_plus1 = {2'b00, p_q} + (PW + 2)'(1);

	// The first p-1 samples only build up the sums.
	assign warm_c = w_q < (p_q - PW'(1));

	// During warm-up sample number w enters the doubled weighted sum with
	// weight 2w+1-p; once the window is full every new sample enters with p-1.
	assign coef = warm_c ? ($signed({1'b0, w_q, 1'b1}) - $signed(CW'(p_q)))
	                     : ($signed(CW'(p_q)) - $signed(CW'(1)));

	// The oldest sample of the window sits p-1 entries behind the write position.
	assign old_sum = {1'b0, pos_q} + (AW + 1)'(MAX_WINDOW) - (AW + 1)'(p_q - PW'(1));
	assign oldest_addr = (old_sum >= (AW + 1)'(MAX_WINDOW))
	                     ? AW'(old_sum - (AW + 1)'(MAX_WINDOW)) : AW'(old_sum);
	assign pos_next = (pos_q == AW'(MAX_WINDOW - 1)) ? '0 : pos_q + AW'(1);

	smma_ring #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (SW)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (pos_q),
		.wdata (sample),
		.re    (accept),
		.raddr (oldest_addr),
		.rdata (ring_rdata)
	);

	// With a window of one the oldest sample is the one written in the same
	// cycle, which the read-first memory does not return, so it is forwarded.
	assign old_sel = (p_q == PW'(1)) ? x_s1 : $signed(ring_rdata);

	// Numerator (p+1)*T + 3*D, formed from registered products.
	assign num_c = NW'(tp_s2) + (NW'(d_q) <<< 1) + NW'(d_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = warm_s1 ? ST_IDLE : ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_MUL);
		out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration and running sums. A write to the window register starts
	// the series over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= PW'(1);
			den_q <= QW'(2);
			pos_q <= '0;
			w_q   <= '0;
			t_q   <= '0;
			d_q   <= '0;
		end else if (cfg_we) begin
			p_q   <= p_new;
			den_q <= den_new;
			pos_q <= '0;
			w_q   <= '0;
			t_q   <= '0;
			d_q   <= '0;
		end else begin
			if (accept) begin
				pos_q <= pos_next;
				t_q   <= t_q + TW'(sample);
				if (warm_c) begin
					w_q <= w_q + PW'(1);
				end
			end
			if (state_q == ST_ACC) begin
				d_q <= d_q + DW'(prod_s1);
			end
			// As the numerator is handed to the divider, the oldest sample leaves both sums.
			if (state_q == ST_MUL) begin
				d_q <= d_q + DW'(oldp_s2) - (DW'(t_q) <<< 1);
				t_q <= t_q - TW'(old_s2);
			end
		end
	end

	// Products, registered in stages s1 (the weighted sample) and s2 (the products with p+1).
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= sample;
			prod_s1 <= coef * sample;
			warm_s1 <= warm_c;
		end
		if (state_q == ST_ACC) begin
			tp_s2   <= t_q * $signed(p_plus1);
			oldp_s2 <= old_sel * $signed(p_plus1);
			old_s2  <= old_sel;
		end
	end

	smma_div #(
		.NW (NW),
		.QW (QW),
		.SW (SW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_c),
		.den    (den_q),
		.avg    (div_avg),
		.status (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q <= div_avg;
			sat_q <= div_stat.sat;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = avg_q;
	assign saturated = sat_q;

endmodule

// ----- rtl/smma_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smma_checker
	import smma_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [CFG_WIDTH-1:0]           window_length,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic signed [SAMPLE_WIDTH-1:0] sample,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] average,
	input logic                           saturated
);

	localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	// No beat is offered while reset is applied.
	`SMMA_ASSERT_RST(a_no_out_in_reset, !arst_n |-> !out_valid, "output valid during reset")

	// One sample is worked on at a time, so an input beat is never followed
	// directly by another one.
	`SMMA_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "input taken twice in a row")

	// A result needs at least the sum update before it can appear.
	`SMMA_ASSERT(a_no_instant_result, in_valid && in_ready |=> !$rose(out_valid), "result too early")

	// A clipped average sits at one end of the sample range.
	`SMMA_ASSERT(a_sat_at_limit, out_valid && saturated |-> average == SMAX || average == SMIN, "saturated flag off limit")

	// A stalled output beat holds.
	`SMMA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(average) && $stable(saturated), "output beat changed")

endmodule

bind sharp_modified_moving_average_top smma_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_smma_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.window_length (window_length),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.sample        (sample),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.average       (average),
	.saturated     (saturated)
);
